>>> rtl/swap_slot_refcount_allocator_unit_macros.svh
`ifndef SWAP_SLOT_REFCOUNT_ALLOCATOR_UNIT_MACROS_SVH
`define SWAP_SLOT_REFCOUNT_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SSRA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssra check failed");

// next-cycle implication
`define SSRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssra check failed");

`endif

>>> rtl/ssra_pkg.sv
package ssra_pkg;

  localparam int SLOT_COUNT    = 16384;
  localparam int SLOT_W        = $clog2(SLOT_COUNT);
  localparam int BIT_W         = 5;
  localparam int WORD_BITS     = 1 << BIT_W;
  localparam int WORD_COUNT    = SLOT_COUNT / WORD_BITS;
  localparam int WORD_W        = SLOT_W - BIT_W;
  localparam int GROUP_COUNT   = WORD_COUNT / WORD_BITS;
  localparam int GROUP_W       = WORD_W - BIT_W;
  localparam int COUNT_W       = 16;
  localparam int FREE_W        = SLOT_W + 1;
  localparam int HANDLE_SHIFT  = 12;
  localparam int IDX_W         = 31 - HANDLE_SHIFT;
  localparam int HANDLE_W      = SLOT_W + HANDLE_SHIFT;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_DUP   = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOSPACE   = 3'd1,
    ST_RANGE     = 3'd2,
    ST_UNUSED    = 3'd3,
    ST_SATURATED = 3'd4
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] slot_handle;
  } in_item_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] alloc_handle;
    status_t             status;
    logic [FREE_W-1:0]   free_slots;
  } out_item_t;

  typedef enum logic [2:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_ALLOC_G,
    CS_ALLOC_W,
    CS_ALLOC_B,
    CS_REF_RD,
    CS_REF_UPD
  } ctl_state_t;

  typedef struct packed {
    logic clr;
    logic take;
    logic alloc_g;
    logic alloc_w;
    logic alloc_commit;
    logic ref_read;
    logic ref_commit;
    logic fin_nospace;
    logic fin_skip;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_alloc;
    logic all_full;
    logic ref_skip;
    logic out_free;
  } dp_sts_t;

  // lowest clear bit of a bitmap word
  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  function automatic logic [GROUP_W-1:0] first_zero_grp(input logic [GROUP_COUNT-1:0] v);
    logic [GROUP_W-1:0] r;
    r = '0;
    for (int i = GROUP_COUNT - 1; i >= 0; i--) begin
      if (!v[i]) r = GROUP_W'(i);
    end
    return r;
  endfunction

  // slot 0 is never handed out, so it counts as taken in word 0
  function automatic logic word_full(input logic [WORD_W-1:0] w,
                                     input logic [WORD_BITS-1:0] d);
    logic [WORD_BITS-1:0] m;
    m = '0;
    m[0] = (w == '0);
    return &(d | m);
  endfunction

endpackage

>>> rtl/ssra_ram.sv
module ssra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ssra_ctrl.sv
module ssra_ctrl
  import ssra_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      CS_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_nxt = CS_IDLE;
      end
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = sts.in_alloc ? CS_ALLOC_G : CS_REF_RD;
        end
      end
      CS_ALLOC_G: begin
        if (sts.all_full) begin
          if (sts.out_free) begin
            cmd.fin_nospace = 1'b1;
            state_nxt       = CS_IDLE;
          end
        end else begin
          cmd.alloc_g = 1'b1;
          state_nxt   = CS_ALLOC_W;
        end
      end
      CS_ALLOC_W: begin
        cmd.alloc_w = 1'b1;
        state_nxt   = CS_ALLOC_B;
      end
      CS_ALLOC_B: begin
        if (sts.out_free) begin
          cmd.alloc_commit = 1'b1;
          state_nxt        = CS_IDLE;
        end
      end
      CS_REF_RD: begin
        if (sts.ref_skip) begin
          if (sts.out_free) begin
            cmd.fin_skip = 1'b1;
            state_nxt    = CS_IDLE;
          end
        end else begin
          cmd.ref_read = 1'b1;
          state_nxt    = CS_REF_UPD;
        end
      end
      CS_REF_UPD: begin
        if (sts.out_free) begin
          cmd.ref_commit = 1'b1;
          state_nxt      = CS_IDLE;
        end
      end
      default: state_nxt = CS_CLEAR;
    endcase
  end

endmodule

>>> rtl/ssra_dp.sv
module ssra_dp
  import ssra_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  ctl_cmd_t  cmd,
  output dp_sts_t   sts
);

  op_t                    op_r;
  logic [IDX_W-1:0]       idx_r;
  logic [GROUP_W-1:0]     g_r;
  logic [BIT_W-1:0]       wb_r;
  logic [GROUP_COUNT-1:0] gfull_r, gfull_nxt;
  logic [FREE_W-1:0]      free_r, free_nxt;
  logic [WORD_W-1:0]      clr_r;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, res;

  logic [SLOT_W-1:0]    slot_idx;
  logic                 range_bad;
  logic [GROUP_W-1:0]   g_enc;
  logic [BIT_W-1:0]     wb_enc, b_enc;
  logic [WORD_W-1:0]    alloc_word, upd_word;
  logic [BIT_W-1:0]     upd_bit;
  logic [GROUP_W-1:0]   upd_grp;
  logic [WORD_BITS-1:0] l0_mask, l0_new, l1_new;
  logic                 busy, nb, nb_sel, nf, free_up, commit, finish;
  logic [COUNT_W-1:0]   cnt_new;
  status_t              ref_status;

  logic                 l0_we, l1_we, cnt_we, l0_re, l1_re;
  logic [WORD_W-1:0]    l0_waddr, l0_raddr;
  logic [GROUP_W-1:0]   l1_waddr, l1_raddr;
  logic [SLOT_W-1:0]    cnt_waddr;
  logic [WORD_BITS-1:0] l0_wdata, l0_rdata, l1_wdata, l1_rdata;
  logic [COUNT_W-1:0]   cnt_wdata, cnt_rdata;

  assign slot_idx   = idx_r[SLOT_W-1:0];
  assign range_bad  = |idx_r[IDX_W-1:SLOT_W];
  assign g_enc      = first_zero_grp(gfull_r);
  assign wb_enc     = first_zero(l1_rdata);
  assign alloc_word = {g_r, wb_r};

  always_comb begin
    l0_mask    = '0;
    l0_mask[0] = (alloc_word == '0);
  end
  assign b_enc = first_zero(l0_rdata | l0_mask);

  // count update for add/drop reference; busy bit marks a live count
  assign busy = l0_rdata[slot_idx[BIT_W-1:0]];

  always_comb begin
    ref_status = ST_OK;
    cnt_new    = cnt_rdata;
    nb         = busy;
    free_up    = 1'b0;
    case (op_r)
      OP_DUP: begin
        if (!busy) begin
          cnt_new    = COUNT_W'(1);
          nb         = 1'b1;
          ref_status = ST_UNUSED;
        end else if (cnt_rdata == COUNT_MAX) begin
          ref_status = ST_SATURATED;
        end else begin
          cnt_new = cnt_rdata + COUNT_W'(1);
        end
      end
      OP_FREE: begin
        if (!busy) begin
          ref_status = ST_UNUSED;
        end else begin
          cnt_new = cnt_rdata - COUNT_W'(1);
          if (cnt_rdata == COUNT_W'(1)) begin
            nb      = 1'b0;
            free_up = 1'b1;
          end
        end
      end
      default: ref_status = ST_OK;
    endcase
  end

  // bitmap update shared by allocate and add/drop
  assign commit   = cmd.alloc_commit | cmd.ref_commit;
  assign upd_word = cmd.alloc_commit ? alloc_word : slot_idx[SLOT_W-1:BIT_W];
  assign upd_bit  = cmd.alloc_commit ? b_enc : slot_idx[BIT_W-1:0];
  assign upd_grp  = upd_word[WORD_W-1:BIT_W];
  assign nb_sel   = cmd.alloc_commit | nb;

  always_comb begin
    l0_new          = l0_rdata;
    l0_new[upd_bit] = nb_sel;
    nf              = word_full(upd_word, l0_new);
    l1_new          = l1_rdata;
    l1_new[upd_word[BIT_W-1:0]] = nf;
    gfull_nxt       = gfull_r;
    if (commit) gfull_nxt[upd_grp] = &l1_new;
  end

  always_comb begin
    free_nxt = free_r;
    if (cmd.alloc_commit && free_r != '0) begin
      free_nxt = free_r - FREE_W'(1);
    end else if (cmd.ref_commit && free_up && free_r < FREE_W'(SLOT_COUNT)) begin
      free_nxt = free_r + FREE_W'(1);
    end
  end

  // RAM ports
  assign l0_we    = cmd.clr | commit;
  assign l0_waddr = cmd.clr ? clr_r : upd_word;
  assign l0_wdata = cmd.clr ? '0 : l0_new;
  assign l0_re    = cmd.alloc_w | cmd.ref_read;
  assign l0_raddr = cmd.alloc_w ? {g_r, wb_enc} : slot_idx[SLOT_W-1:BIT_W];

  assign l1_we    = (cmd.clr && clr_r[WORD_W-1:GROUP_W] == '0) | commit;
  assign l1_waddr = cmd.clr ? clr_r[GROUP_W-1:0] : upd_grp;
  assign l1_wdata = cmd.clr ? '0 : l1_new;
  assign l1_re    = cmd.alloc_g | cmd.ref_read;
  assign l1_raddr = cmd.alloc_g ? g_enc : slot_idx[SLOT_W-1:SLOT_W-GROUP_W];

  assign cnt_we    = commit;
  assign cnt_waddr = cmd.alloc_commit ? {alloc_word, b_enc} : slot_idx;
  assign cnt_wdata = cmd.alloc_commit ? COUNT_W'(1) : cnt_new;

  ssra_ram #(.WIDTH(WORD_BITS), .DEPTH(WORD_COUNT)) u_l0_ram (
    .clk   (clk),
    .we    (l0_we),
    .waddr (l0_waddr),
    .wdata (l0_wdata),
    .re    (l0_re),
    .raddr (l0_raddr),
    .rdata (l0_rdata)
  );

  ssra_ram #(.WIDTH(WORD_BITS), .DEPTH(GROUP_COUNT)) u_l1_ram (
    .clk   (clk),
    .we    (l1_we),
    .waddr (l1_waddr),
    .wdata (l1_wdata),
    .re    (l1_re),
    .raddr (l1_raddr),
    .rdata (l1_rdata)
  );

  ssra_ram #(.WIDTH(COUNT_W), .DEPTH(SLOT_COUNT)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cmd.ref_read),
    .raddr (slot_idx),
    .rdata (cnt_rdata)
  );

  // result
  assign finish = commit | cmd.fin_nospace | cmd.fin_skip;

  always_comb begin
    res.alloc_handle = '0;
    res.free_slots   = free_nxt;
    res.status       = ST_OK;
    if (cmd.alloc_commit) begin
      res.alloc_handle = {alloc_word, b_enc, {HANDLE_SHIFT{1'b0}}};
    end else if (cmd.fin_nospace) begin
      res.status = ST_NOSPACE;
    end else if (cmd.fin_skip) begin
      res.status = (op_r != OP_NOP && range_bad) ? ST_RANGE : ST_OK;
    end else if (cmd.ref_commit) begin
      res.status = ref_status;
    end
  end

  assign out_valid_nxt = finish | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      gfull_r     <= '0;
      free_r      <= FREE_W'(SLOT_COUNT);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_r <= clr_r + WORD_W'(1);
      gfull_r     <= gfull_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r  <= in_data.op;
      idx_r <= in_data.slot_handle[HANDLE_SHIFT+IDX_W-1:HANDLE_SHIFT];
    end
    if (cmd.alloc_g) g_r <= g_enc;
    if (cmd.alloc_w) wb_r <= wb_enc;
    if (finish) out_data_r <= res;
  end

  assign sts.clr_done = (clr_r == WORD_W'(WORD_COUNT - 1));
  assign sts.in_alloc = (in_data.op == OP_ALLOC);
  assign sts.all_full = &gfull_r;
  assign sts.ref_skip = (op_r == OP_NOP) || range_bad;
  assign sts.out_free = ~out_valid_r | out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/swap_slot_refcount_allocator_unit.sv
// Reference-counted slot allocator, first-fit from slot 1 upward.
// Input channel in_valid/in_ready/in_data carries {op, slot_handle}; each
// transfer produces exactly one result on out_valid/out_ready/out_data
// {alloc_handle, status, free_slots}, in order.
// From the input transfer, allocate passes states ALLOC_G, ALLOC_W and
// ALLOC_B and add/drop REF_RD and REF_UPD before the result is
// registered; no-op, out-of-range and allocate with no free slot finish
// from their first state. One item is in flight at a time; a new item
// can be taken the cycle after its predecessor's result is registered.
// Allocate walks a three-level busy bitmap (group flags, word
// flags RAM, bit RAM), one level per cycle, the last one waiting for
// a free output register; add/drop reads count and bitmap RAMs together
// and writes them back once the output register is free. After reset the
// bitmap RAMs are cleared, one word a cycle, with in_ready low. Counts are
// valid only where the busy bit is set, so the count RAM is never cleared.
// The result sits in an output register; while the receiver stalls, the
// next item may still be taken and runs up to its final step, where it
// waits until the register is free.
`include "swap_slot_refcount_allocator_unit_macros.svh"

module swap_slot_refcount_allocator_unit
  import ssra_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  ssra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssra_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  `SSRA_ASSERT_NOW(a_free_bound, out_valid, out_data.free_slots <= FREE_W'(SLOT_COUNT))
  `SSRA_ASSERT_NOW(a_handle_ok_only, out_valid && out_data.status != ST_OK,
                   out_data.alloc_handle == '0)
  `SSRA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `SSRA_ASSERT_NOW(a_single_cmd, 1'b1,
                   $onehot0({cmd.clr, cmd.take, cmd.alloc_g, cmd.alloc_w, cmd.alloc_commit,
                             cmd.ref_read, cmd.ref_commit, cmd.fin_nospace, cmd.fin_skip}))

endmodule
